/* sv/mf3_pkg.sv */
`default_nettype none
package mf3_pkg;

  // Pixel and configuration widths fixed by the stream format
  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int LINE_WIDTH_RST = 640;
  localparam int MIN_LINE_WIDTH = 3;

  // 3x3 window: nine taps, median is the fifth smallest
  localparam int WIN_N   = 9;
  localparam int MED_IDX = 4;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

endpackage
`default_nettype wire

/* sv/median_filter_3x3.sv */
`default_nettype none
// 3x3 median filter over a raster stream of 8-bit grayscale pixels. One pixel
// is taken per clock, sustained, as long as results are taken as fast; the
// pixel that completes a window passes through the line-buffer read at the
// accepting edge, then the queue, the window, three exchange-network stages
// and the output register, where its result is valid. in_tuser
// marks the first pixel of a frame,
// which lands at row 0, column 0. For every pixel at row r>=2 and column
// c>=2 the block returns the median of its 3x3 neighborhood centered at
// (r-1, c-1) with those coordinates; border pixels produce nothing. Row length
// is taken from cfg_wr_data (clamped to 3..MAX_WIDTH, 640 after reset) and
// should be changed only while the block is idle. The two line buffers are
// MAX_WIDTH x 8 RAMs with no clearing after reset: a frame must start with a
// full row before the buffers hold meaningful data, as the raster order does.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW     = $clog2(MAX_WIDTH),
  localparam int RW     = $clog2(MAX_HEIGHT),
  localparam int OUT_TW = ((mf3_pkg::PIX_W + RW + CW + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [mf3_pkg::CFG_W-1:0] cfg_wr_data,   // line_width
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [7:0]                in_tdata,      // pixel
  input  wire logic                      in_tuser,      // frame_start
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_TW-1:0]              out_tdata      // median_value, out_row, out_col
);

  localparam int QW = 3 * mf3_pkg::PIX_W + 1 + RW + CW;

  logic [mf3_pkg::CFG_W-1:0] line_width_r;

  logic          f_push, f_prod, q_room, q_valid, q_pop, b_prod;
  mf3_pkg::pix_t f_top, f_mid, f_px, b_top, b_mid, b_px, o_med;
  logic [RW-1:0] f_row, b_row, o_row;
  logic [CW-1:0] f_col, b_col, o_col;
  logic [QW-1:0] q_wdata, q_rdata;

  // Row length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= mf3_pkg::CFG_W'(mf3_pkg::LINE_WIDTH_RST);
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  mf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_width     (line_width_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_pixel       (in_tdata),
    .in_frame_start (in_tuser),
    .q_room         (q_room),
    .q_push         (f_push),
    .q_top          (f_top),
    .q_mid          (f_mid),
    .q_px           (f_px),
    .q_produce      (f_prod),
    .q_row          (f_row),
    .q_col          (f_col)
  );

  assign q_wdata = {f_top, f_mid, f_px, f_prod, f_row, f_col};

  mf3_fifo #(.WIDTH(QW), .DEPTH(mf3_pkg::Q_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wr_data  (q_wdata),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata),
    .room2    (q_room)
  );

  assign {b_top, b_mid, b_px, b_prod, b_row, b_col} = q_rdata;

  mf3_back #(.CW(CW), .RW(RW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_top      (b_top),
    .q_mid      (b_mid),
    .q_px       (b_px),
    .q_produce  (b_prod),
    .q_row      (b_row),
    .q_col      (b_col),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_median (o_med),
    .out_row    (o_row),
    .out_col    (o_col)
  );

  assign out_tdata = OUT_TW'({o_col, o_row, o_med});

endmodule
`default_nettype wire

/* sv/mf3_ram.sv */
`default_nettype none
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* sv/mf3_front.sv */
`default_nettype none
module mf3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [mf3_pkg::CFG_W-1:0]  line_width,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mf3_pkg::pix_t              in_pixel,
  input  wire logic                       in_frame_start,
  input  wire logic                       q_room,
  output logic                            q_push,
  output mf3_pkg::pix_t                   q_top,
  output mf3_pkg::pix_t                   q_mid,
  output mf3_pkg::pix_t                   q_px,
  output logic                            q_produce,
  output logic [RW-1:0]                   q_row,
  output logic [CW-1:0]                   q_col
);

  // Last column index of a row, width clamped to the legal range
  function automatic logic [CW-1:0] last_col_of(logic [mf3_pkg::CFG_W-1:0] w);
    int ew;
    ew = int'(w);
    if (ew < mf3_pkg::MIN_LINE_WIDTH) ew = mf3_pkg::MIN_LINE_WIDTH;
    if (ew > MAX_WIDTH) ew = MAX_WIDTH;
    return CW'(ew - 1);
  endfunction

  logic          acc;
  logic [CW-1:0] col_r, col_nxt, col_cur, last_col;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic          prod_cur;

  logic          s1_v_r;
  logic [CW-1:0] s1_idx_r;
  mf3_pkg::pix_t s1_px_r;
  logic          s1_prod_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_hit_r;
  mf3_pkg::pix_t s1_prev_mid_r;

  mf3_pkg::pix_t up_rd, mid_rd;

  // Accept only when the queue can also take the item already in flight
  assign in_ready = q_room;
  assign acc      = in_valid && in_ready;

  // Raster position of the arriving pixel
  always_comb begin
    col_cur  = in_frame_start ? '0 : col_r;
    row_cur  = in_frame_start ? '0 : row_r;
    last_col = last_col_of(line_width);
    prod_cur = (int'(row_cur) >= 2) && (int'(col_cur) >= 2);
    if (col_cur >= last_col) begin
      col_nxt = '0;
      if (int'(row_cur) + 1 >= MAX_HEIGHT) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_cur + RW'(1);
      end
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Stage 1 payload, waits beside the line-buffer read data
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_idx_r      <= col_cur;
      s1_px_r       <= in_pixel;
      s1_prod_r     <= prod_cur;
      s1_row_r      <= row_cur - RW'(1);
      s1_col_r      <= col_cur - CW'(1);
      // upper write of the previous item lands at this same edge
      s1_hit_r      <= s1_v_r && (s1_idx_r == col_cur);
      s1_prev_mid_r <= mid_rd;
    end
  end

  // Middle line: new pixel goes in, old row r-1 comes out
  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (acc),
    .waddr (col_cur),
    .wdata (in_pixel),
    .re    (acc),
    .raddr (col_cur),
    .rdata (mid_rd)
  );

  // Upper line: written from the stage-1 registers with the middle read data
  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_idx_r),
    .wdata (mid_rd),
    .re    (acc),
    .raddr (col_cur),
    .rdata (up_rd)
  );

  assign q_push    = s1_v_r;
  assign q_top     = s1_hit_r ? s1_prev_mid_r : up_rd;
  assign q_mid     = mid_rd;
  assign q_px      = s1_px_r;
  assign q_produce = s1_prod_r;
  assign q_row     = s1_row_r;
  assign q_col     = s1_col_r;

  // Row counter never leaves the frame height
  assert property (@(posedge clk) disable iff (!rst_n) int'(row_r) < MAX_HEIGHT)
    else $error("row position out of range");

  // A bypass hit needs an item in stage 1 on the previous cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_v_r && (s1_idx_r == col_cur)) |=> s1_hit_r && s1_v_r)
    else $error("line buffer bypass missed");

endmodule
`default_nettype wire

/* sv/mf3_fifo.sv */
`default_nettype none
module mf3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic                  rd_valid,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  room2
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      priority if (push && !pop) count_r <= count_r + NW'(1);
      else if (pop && !push)     count_r <= count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  // room for the item in flight plus one more
  assign room2    = (int'(count_r) <= DEPTH - 2);

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (int'(count_r) < DEPTH) || pop)
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_r != '0)
    else $error("queue underflow");

endmodule
`default_nettype wire

/* sv/mf3_back.sv */
`default_nettype none
module mf3_back #(
  parameter int CW = 10,
  parameter int RW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire mf3_pkg::pix_t q_top,
  input  wire mf3_pkg::pix_t q_mid,
  input  wire mf3_pkg::pix_t q_px,
  input  wire logic          q_produce,
  input  wire logic [RW-1:0] q_row,
  input  wire logic [CW-1:0] q_col,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mf3_pkg::pix_t      out_median,
  output logic [RW-1:0]      out_row,
  output logic [CW-1:0]      out_col
);

  localparam int NST = 4;  // window stage plus three sorting stages

  // Compare-exchange: smaller value to index a, larger to index b
  function automatic mf3_pkg::win_t cx(mf3_pkg::win_t v, int a, int b);
    mf3_pkg::win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  logic          adv;
  mf3_pkg::win_t win_r;
  mf3_pkg::win_t st1_r, st2_r, st3_r;
  mf3_pkg::win_t net_a, net_b, net_c, net_d;
  logic [NST-1:0] v_r;
  logic [RW-1:0] row_r [NST];
  logic [CW-1:0] col_r [NST];
  logic          ov_r;
  mf3_pkg::pix_t omed_r;
  logic [RW-1:0] orow_r;
  logic [CW-1:0] ocol_r;

  // Whole pipeline moves unless a result is held at the output
  assign adv   = !ov_r || out_ready;
  assign q_pop = adv && q_valid;

  // Median-of-nine exchange network, split over four levels
  always_comb begin
    net_a = cx(win_r, 1, 2);
    net_a = cx(net_a, 4, 5);
    net_a = cx(net_a, 7, 8);
    net_a = cx(net_a, 0, 1);
    net_a = cx(net_a, 3, 4);
    net_a = cx(net_a, 6, 7);

    net_b = cx(st1_r, 1, 2);
    net_b = cx(net_b, 4, 5);
    net_b = cx(net_b, 7, 8);
    net_b = cx(net_b, 0, 3);
    net_b = cx(net_b, 5, 8);
    net_b = cx(net_b, 4, 7);

    net_c = cx(st2_r, 3, 6);
    net_c = cx(net_c, 1, 4);
    net_c = cx(net_c, 2, 5);
    net_c = cx(net_c, 4, 7);

    net_d = cx(st3_r, 4, 2);
    net_d = cx(net_d, 6, 4);
    net_d = cx(net_d, 4, 2);
  end

  // Control: stage valids and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[NST-2:0], q_pop && q_produce};
      ov_r <= v_r[NST-1];
    end
  end

  // Window shifts one column per item, produced or not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (q_pop) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= q_top;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= q_mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= q_px;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      row_r[0] <= q_row;
      col_r[0] <= q_col;
      for (int i = 1; i < NST; i++) begin
        row_r[i] <= row_r[i-1];
        col_r[i] <= col_r[i-1];
      end
      st1_r  <= net_a;
      st2_r  <= net_b;
      st3_r  <= net_c;
      omed_r <= net_d[mf3_pkg::MED_IDX];
      orow_r <= row_r[NST-1];
      ocol_r <= col_r[NST-1];
    end
  end

  assign out_valid  = ov_r;
  assign out_median = omed_r;
  assign out_row    = orow_r;
  assign out_col    = ocol_r;

  // A held result must not be overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(omed_r) && $stable(orow_r))
    else $error("held result changed");

endmodule
`default_nettype wire
